// File: rtl/console_receive_fifo_unit_macros.svh
// Assertion macros used by the console receive FIFO unit.
`ifndef CONSOLE_RECEIVE_FIFO_UNIT_MACROS_SVH
`define CONSOLE_RECEIVE_FIFO_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/crf_pkg.sv
package crf_pkg;

    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CHAR_W = 8;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_NONE = 1'b1;

    localparam char_t CHAR_NUL = 8'h00;
    localparam char_t CHAR_BS  = 8'h08;
    localparam char_t CHAR_LF  = 8'h0A;
    localparam char_t CHAR_CR  = 8'h0D;
    localparam char_t CHAR_DEL = 8'h7F;

    function automatic char_t translate_char(input char_t b);
        char_t r;
        if (b == CHAR_CR)
        begin
            r = CHAR_LF;
        end
        else if (b == CHAR_DEL)
        begin
            r = CHAR_BS;
        end
        else
        begin
            r = b;
        end
        return r;
    endfunction

endpackage

// File: rtl/crf_in_if.sv
interface crf_in_if;
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    crf_pkg::char_t       dev_byte;

    modport source (output valid, output cmd, output dev_byte, input ready);
    modport sink   (input valid, input cmd, input dev_byte, output ready);
endinterface

// File: rtl/crf_out_if.sv
interface crf_out_if;
    logic                 valid;
    logic                 ready;
    logic                 status;
    crf_pkg::char_t       rx_char;

    modport source (output valid, output status, output rx_char, input ready);
    modport sink   (input valid, input status, input rx_char, output ready);
endinterface

// File: rtl/crf_char_ram.sv
module crf_char_ram #(
    parameter int DEPTH_P = 1024,
    parameter int WIDTH_P = 8,
    parameter int ADDR_W  = $clog2(DEPTH_P)
) (
    input  logic               clk,
    input  logic               en,
    input  logic               we,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [WIDTH_P-1:0] wdata,
    output logic [WIDTH_P-1:0] rdata
);

    logic [WIDTH_P-1:0] mem_reg [DEPTH_P];
    logic [WIDTH_P-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/console_receive_fifo_unit.sv
// Receive FIFO for a serial console. A poll request (cmd = 0) carries a device byte; a nonzero
// byte is translated (carriage return to newline, DEL to backspace) and stored in a
// 1024-entry single-port ring memory, unless the ring is full or the block is in drop mode,
// which a full ring enters and only a zero byte leaves. A read request (cmd = 1) returns the
// oldest stored character, or with an empty ring the translated device byte itself, with
// status 1 when that byte is zero. Poll requests are taken one per cycle. A read from a
// non-empty ring stalls the next request, as the ring memory has one port and a registered
// read: the port is busy for the read and the next request waits for the data.
// An empty-ring read needs no memory access. Results sit in an output register, and
// while a result waits there for the consumer, no request of either kind is taken.
`include "console_receive_fifo_unit_macros.svh"

module console_receive_fifo_unit (
    input  logic   clk,
    input  logic   rst_n,
    crf_in_if.sink   in_ch,
    crf_out_if.source out_ch
);

    localparam logic [crf_pkg::CNT_W:0] DEPTH_SUM = (crf_pkg::CNT_W + 1)'(crf_pkg::DEPTH);
    localparam crf_pkg::cnt_t           DEPTH_CNT = crf_pkg::CNT_W'(crf_pkg::DEPTH);
    localparam crf_pkg::idx_t           LAST_IDX  = crf_pkg::IDX_W'(crf_pkg::DEPTH - 1);

    crf_pkg::idx_t  read_index_reg, read_index_next;
    crf_pkg::cnt_t  fill_count_reg, fill_count_next;
    logic           dropping_reg, dropping_next;
    logic           pend_reg, pend_next;
    logic           out_valid_reg, out_valid_next;
    logic           status_reg, status_next;
    crf_pkg::char_t rx_char_reg, rx_char_next;

    logic                  accept;
    logic                  is_read;
    logic                  byte_zero;
    logic                  ring_empty;
    logic                  ring_full;
    logic                  store;
    logic                  pop;
    logic                  direct;
    logic [crf_pkg::CNT_W:0] wsum;
    crf_pkg::idx_t         waddr;
    crf_pkg::idx_t         ram_addr;
    crf_pkg::char_t        ram_rdata;
    crf_pkg::char_t        dev_char;

    assign in_ch.ready = !pend_reg && (!out_valid_reg || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_read     = (in_ch.cmd == crf_pkg::CMD_READ);
    assign byte_zero   = (in_ch.dev_byte == crf_pkg::CHAR_NUL);
    assign ring_empty  = (fill_count_reg == '0);
    assign ring_full   = (fill_count_reg == DEPTH_CNT);
    assign store       = accept && !is_read && !byte_zero && !dropping_reg && !ring_full;
    assign pop         = accept && is_read && !ring_empty;
    assign direct      = accept && is_read && ring_empty;
    assign dev_char    = crf_pkg::translate_char(in_ch.dev_byte);

    // The write slot is read_index + fill_count modulo the depth; the sum stays below twice the depth.
    assign wsum = (crf_pkg::CNT_W + 1)'(read_index_reg) + (crf_pkg::CNT_W + 1)'(fill_count_reg);

    always_comb
    begin
        if (wsum >= DEPTH_SUM)
        begin
            waddr = crf_pkg::IDX_W'(wsum - DEPTH_SUM);
        end
        else
        begin
            waddr = crf_pkg::IDX_W'(wsum);
        end
    end

    assign ram_addr = store ? waddr : read_index_reg;

    crf_char_ram #(
        .DEPTH_P (crf_pkg::DEPTH),
        .WIDTH_P (crf_pkg::CHAR_W)
    ) u_char_ram (
        .clk   (clk),
        .en    (store || pop),
        .we    (store),
        .addr  (ram_addr),
        .wdata (dev_char),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        read_index_next = read_index_reg;
        fill_count_next = fill_count_reg;
        dropping_next   = dropping_reg;
        pend_next       = pop;

        if (accept && !is_read)
        begin
            if (byte_zero)
            begin
                dropping_next = 1'b0;
            end
            else if (ring_full)
            begin
                dropping_next = 1'b1;
            end
        end

        if (store)
        begin
            fill_count_next = fill_count_reg + crf_pkg::CNT_W'(1);
        end
        else if (pop)
        begin
            fill_count_next = fill_count_reg - crf_pkg::CNT_W'(1);
            if (read_index_reg == LAST_IDX)
            begin
                read_index_next = '0;
            end
            else
            begin
                read_index_next = read_index_reg + crf_pkg::IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        rx_char_next   = rx_char_reg;
        priority if (pend_reg)
        begin
            out_valid_next = 1'b1;
            status_next    = crf_pkg::STATUS_OK;
            rx_char_next   = ram_rdata;
        end
        else if (direct)
        begin
            out_valid_next = 1'b1;
            status_next    = byte_zero ? crf_pkg::STATUS_NONE : crf_pkg::STATUS_OK;
            rx_char_next   = dev_char;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_index_reg <= '0;
            fill_count_reg <= '0;
            dropping_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            read_index_reg <= read_index_next;
            fill_count_reg <= fill_count_next;
            dropping_reg   <= dropping_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        rx_char_reg <= rx_char_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.status  = status_reg;
    assign out_ch.rx_char = rx_char_reg;

    `CRF_ASSERT_SAME(a_fill_bound, 1'b1, fill_count_reg <= DEPTH_CNT, "fill count above depth")
    `CRF_ASSERT_SAME(a_index_bound, 1'b1, read_index_reg <= LAST_IDX, "read index out of range")
    `CRF_ASSERT_SAME(a_pend_slot_free, pend_reg, !out_valid_reg, "output busy when ring data returns")
    `CRF_ASSERT_NEXT(a_pend_delivers, pend_reg, out_valid_reg, "ring read produced no result")
    `CRF_ASSERT_NEXT(a_pop_count, pop, pend_reg && fill_count_reg == $past(fill_count_reg) - crf_pkg::CNT_W'(1), "pop did not take one entry")

endmodule

// File: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crf_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int MIX_ITEMS    = 100;
    localparam int FILL_ITEMS   = 1130;
    localparam int DRAIN_ITEMS  = 280;
    localparam int DROP_CLEAR_AT = 200;

    typedef struct {
        logic  cmd;
        char_t dev_byte;
        bit    typed;
        logic  status;
        char_t rx_char;
    } request_t;

    typedef struct {
        logic  status;
        char_t rx_char;
    } rx_result_t;

    logic clk = 1'b0;
    logic rst_n;

    crf_in_if  in_ch ();
    crf_out_if out_ch ();

    console_receive_fifo_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Rows with typed set carry a result that can be read straight off the behavior.
    request_t directed_rows [22] = '{
        '{CMD_READ, CHAR_NUL, 1'b1, STATUS_NONE, CHAR_NUL},
        '{CMD_READ, CHAR_CR,  1'b1, STATUS_OK,   CHAR_LF},
        '{CMD_READ, CHAR_DEL, 1'b1, STATUS_OK,   CHAR_BS},
        '{CMD_READ, 8'hFF,    1'b1, STATUS_OK,   8'hFF},
        '{CMD_READ, 8'h01,    1'b1, STATUS_OK,   8'h01},
        '{CMD_POLL, CHAR_NUL, 1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_POLL, CHAR_CR,  1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_POLL, CHAR_DEL, 1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_POLL, 8'hFF,    1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_POLL, 8'h80,    1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_READ, CHAR_NUL, 1'b1, STATUS_OK,   CHAR_LF},
        '{CMD_READ, 8'hFF,    1'b1, STATUS_OK,   CHAR_BS},
        '{CMD_READ, 8'h33,    1'b1, STATUS_OK,   8'hFF},
        '{CMD_READ, CHAR_NUL, 1'b1, STATUS_OK,   8'h80},
        '{CMD_READ, CHAR_NUL, 1'b1, STATUS_NONE, CHAR_NUL},
        '{CMD_POLL, 8'h41,    1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_READ, CHAR_CR,  1'b1, STATUS_OK,   8'h41},
        '{CMD_POLL, 8'h01,    1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_POLL, 8'hFE,    1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_READ, CHAR_DEL, 1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_READ, CHAR_NUL, 1'b0, STATUS_OK,   CHAR_NUL},
        '{CMD_READ, CHAR_NUL, 1'b1, STATUS_NONE, CHAR_NUL}
    };

    request_t   request_q [$];
    rx_result_t pending_chars [$];

    char_t ring_model [DEPTH];
    int    ring_head;
    int    ring_fill;
    bit    drop_mode;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int results_seen   = 0;

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic char_t console_translate(input char_t b);
        case (b)
            CHAR_CR:  return CHAR_LF;
            CHAR_DEL: return CHAR_BS;
            default:  return b;
        endcase
    endfunction

    function automatic void console_step(input request_t req, output bit has_result,
                                         output rx_result_t res);
        has_result = 1'b0;
        res = '{STATUS_NONE, CHAR_NUL};
        if (req.cmd == CMD_POLL)
        begin
            if (req.dev_byte == CHAR_NUL)
            begin
                drop_mode = 1'b0;
            end
            else if (!drop_mode)
            begin
                if (ring_fill >= DEPTH)
                begin
                    drop_mode = 1'b1;
                end
                else
                begin
                    ring_model[(ring_head + ring_fill) % DEPTH] = console_translate(req.dev_byte);
                    ring_fill++;
                end
            end
        end
        else
        begin
            has_result = 1'b1;
            if (ring_fill == 0)
            begin
                if (req.dev_byte == CHAR_NUL)
                begin
                    res = '{STATUS_NONE, CHAR_NUL};
                end
                else
                begin
                    res = '{STATUS_OK, console_translate(req.dev_byte)};
                end
            end
            else
            begin
                res = '{STATUS_OK, ring_model[ring_head]};
                ring_head = (ring_head + 1) % DEPTH;
                ring_fill--;
            end
        end
    endfunction

    function automatic char_t random_dev_byte(input bit allow_nul);
        int pick;
        pick = $urandom_range(0, 15);
        if (allow_nul && pick < 4)
        begin
            return CHAR_NUL;
        end
        if (pick == 4)
        begin
            return CHAR_CR;
        end
        if (pick == 5)
        begin
            return CHAR_DEL;
        end
        return char_t'($urandom_range(1, 255));
    endfunction

    function automatic void add_request(input logic cmd, input char_t b);
        request_t req;
        req = '{cmd, b, 1'b0, STATUS_OK, CHAR_NUL};
        request_q.push_back(req);
    endfunction

    function automatic void add_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            add_request(($urandom_range(0, 1) == 1) ? CMD_READ : CMD_POLL,
                        random_dev_byte(1'b1));
        end
    endfunction

    initial
    begin
        int         next_idx;
        int         burst_left;
        int         gap_left;
        logic       drive_valid;
        bit         has_result;
        rx_result_t res;

        in_ch.valid    <= 1'b0;
        in_ch.cmd      <= CMD_POLL;
        in_ch.dev_byte <= CHAR_NUL;
        rst_n          <= 1'b0;
        ring_head = 0;
        ring_fill = 0;
        drop_mode = 1'b0;

        foreach (directed_rows[i])
        begin
            request_q.push_back(directed_rows[i]);
        end
        add_random_mix(MIX_ITEMS);
        // Fill the ring past full so that drop mode is entered, with a little noise.
        for (int i = 0; i < FILL_ITEMS; i++)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                add_request(CMD_READ, random_dev_byte(1'b1));
            end
            else if ($urandom_range(0, 59) == 0)
            begin
                add_request(CMD_POLL, CHAR_NUL);
            end
            else
            begin
                add_request(CMD_POLL, random_dev_byte(1'b0));
            end
        end
        // Drain part of it while device bytes keep arriving, leaving drop mode late on,
        // so that bytes are still dropped after space has become free.
        for (int i = 0; i < DRAIN_ITEMS; i++)
        begin
            if (i == DROP_CLEAR_AT)
            begin
                add_request(CMD_POLL, CHAR_NUL);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                add_request(CMD_POLL, random_dev_byte(1'b0));
            end
            else
            begin
                add_request(CMD_READ, random_dev_byte(1'b1));
            end
        end
        add_random_mix(MIX_ITEMS);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        next_idx   = 0;
        gap_left   = 0;
        burst_left = $urandom_range(1, 12);
        while (next_idx < request_q.size())
        begin
            @(posedge clk);
            if (in_ch.valid && in_ch.ready)
            begin
                console_step(request_q[next_idx], has_result, res);
                if (has_result)
                begin
                    if (request_q[next_idx].typed)
                    begin
                        res = '{request_q[next_idx].status, request_q[next_idx].rx_char};
                    end
                    pending_chars.push_back(res);
                end
                next_idx++;
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                drive_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (next_idx < request_q.size())
                begin
                    drive_valid = 1'b1;
                    in_ch.cmd      <= request_q[next_idx].cmd;
                    in_ch.dev_byte <= request_q[next_idx].dev_byte;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        gap_left = $urandom_range(0, 5);
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left = $urandom_range(100, 300);
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 12);
                        end
                    end
                end
                in_ch.valid <= drive_valid;
            end
        end

        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        int         hold_left;
        int         mode;
        int         mode_left;
        bit         held;
        logic       next_ready;
        rx_result_t want;

        out_ch.ready <= 1'b0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (pending_chars.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual status %0d char %02h",
                             $time, out_ch.status, out_ch.rx_char);
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (out_ch.status !== want.status)
                    begin
                        mismatch_count++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, out_ch.status);
                    end
                    if (out_ch.rx_char !== want.rx_char)
                    begin
                        mismatch_count++;
                        $display("%0t: rx_char mismatch, expected %02h, actual %02h",
                                 $time, want.rx_char, out_ch.rx_char);
                    end
                end
            end

            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;

            // One long hold-off lets the result register back up and stall requests.
            if (!rst_n)
            begin
                next_ready = 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (!held && results_seen >= HOLD_AFTER)
            begin
                held       = 1'b1;
                hold_left  = HOLD_CYCLES;
                next_ready = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       next_ready = 1'b1;
                    1:       next_ready = ($urandom_range(0, 3) != 0);
                    2:       next_ready = ((mode_left % 3) != 0);
                    default: next_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
            out_ch.ready <= next_ready;
        end
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/crf_pkg.sv
rtl/crf_in_if.sv
rtl/crf_out_if.sv
rtl/crf_char_ram.sv
rtl/console_receive_fifo_unit.sv
bench/testbench.sv
